/* rtl/tpi_pkg.sv */
// package for the thick polyline intersection block
// request/result types, sequencer states, sine table function; no dependencies
package tpi_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam logic [15:0] HALF_WIDTH_RESET = 16'd256;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic        opcode;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic [15:0] heading;
    } req_t;

    typedef struct packed {
        logic hit;
        logic overflow;
    } res_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_AP_COS,
        S_AP_SIN,
        S_AP_OFS,
        S_AP_WR0,
        S_AP_WR1,
        S_Q_LINE0,
        S_Q_LINE1,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_E0,
        S_Q_E1,
        S_Q_E2,
        S_Q_E3,
        S_Q_E4,
        S_Q_E5,
        S_Q_E6,
        S_Q_E7,
        S_Q_E8,
        S_Q_E9,
        S_Q_E10,
        S_Q_E11,
        S_Q_E12,
        S_Q_B0,
        S_Q_B1,
        S_Q_B2,
        S_Q_B3,
        S_Q_B4,
        S_Q_B5,
        S_Q_B6,
        S_Q_B7,
        S_Q_CHK,
        S_DONE
    } state_t;

    // magnitude product shifted right by 30, sign restored
    function automatic logic signed [63:0] qmul30(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [127:0] p;
        logic [63:0] m;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p = ma * mb;
        m = p[93:30];
        return (a[63] != b[63]) ? -$signed(m) : $signed(m);
    endfunction

    // sine table entry for phase p (16 bit turn), signed q14
    function automatic logic signed [15:0] sine_entry(input logic [15:0] p);
        logic [1:0] q;
        logic [14:0] r;
        logic signed [63:0] u;
        logic signed [63:0] u2;
        logic signed [63:0] s;
        logic [63:0] v;
        q = p[15:14];
        r = {1'b0, p[13:0]};
        if (q[0])
            r = 15'd16384 - r;
        u = 64'(r) <<< 16;
        u2 = qmul30(u, u);
        s = 64'sd172272;
        s = -64'sd5026995 + qmul30(s, u2);
        s = 64'sd85569306 + qmul30(s, u2);
        s = -64'sd693598668 + qmul30(s, u2);
        s = 64'sd1686629713 + qmul30(s, u2);
        s = qmul30(s, u);
        if (s < 0)
            s = 0;
        v = (64'(s) + 64'd32768) >> 16;
        if (v > 64'd16384)
            v = 64'd16384;
        return q[1] ? -$signed(16'(v)) : $signed(16'(v));
    endfunction

endpackage

/* rtl/tpi_sine_rom.sv */
// sine lookup table, registered read
// depends on tpi_pkg for the entry function
module tpi_sine_rom #(
    parameter int DEPTH = tpi_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic [15:0]              angle,
    output logic signed [15:0]       value
);
    import tpi_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic signed [15:0] rom [DEPTH];
    logic [AW-1:0] idx;

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
            rom[k] = sine_entry(16'((longint'(k) * 65536) / DEPTH));
    end

    assign idx = AW'((32'(angle) * 32'(DEPTH)) >> 16);

    always_ff @(posedge clk)
    begin
        value <= rom[idx];
    end
endmodule

/* rtl/tpi_vertex_ram.sv */
// vertex store, one write port and one registered read port
// no package dependency
module tpi_vertex_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic signed [23:0]            wx,
    input  logic signed [23:0]            wy,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic signed [23:0]            rx,
    output logic signed [23:0]            ry
);
    logic [47:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {wx, wy};
        {rx, ry} <= mem[raddr];
    end
endmodule

/* rtl/tpi_mul.sv */
// shared signed multiplier, 32x32 bits with registered product
// no package dependency
module tpi_mul (
    input  logic                clk,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    output logic signed [63:0]  p
);
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end
endmodule

/* rtl/thick_polyline_intersection.sv */
// top level of the thick polyline intersection block
// depends on tpi_pkg, tpi_sine_rom, tpi_vertex_ram, tpi_mul
//
// usage: drive req and pulse start while busy is low; the request is taken at
// that edge and busy stays high until the result. The result (hit, overflow)
// is on res for one cycle with done high; the receiver cannot stall it.
// append: stores two outline vertices from the sine table and half_width; when
// the store is full it stores nothing, sets overflow and ends early.
// query: with 4 or more vertices stored, each stored edge is walked through one
// shared 32x32 multiplier and its product register (wide products and the
// bounding box products are built from 32-bit partial products); a hit ends
// the walk early. With fewer vertices stored, no edge is checked.
// a new request is taken at the earliest in the cycle after done; the block
// takes no new request before it is through with the last one.
// half_width is written on the cfg channel (cfg_valid/cfg_ready); the user
// must write it only while idle, the block itself does not enforce it.
// cfg_ready is always high. Reset clears the vertex count and sets half_width
// to 1.0; the vertex memory is not cleared, entries are only read below the
// count.
module thick_polyline_intersection #(
    parameter int MAX_VERTICES = tpi_pkg::MAX_VERTICES_DEF,
    parameter int SINE_TABLE_DEPTH = tpi_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tpi_pkg::req_t  req,
    output logic           done,
    output tpi_pkg::res_t  res,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);
    import tpi_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    state_t state_reg, state_next;
    logic [15:0] hw_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg, idx_next;
    req_t req_reg;
    logic hit_reg, ovf_reg;

    logic [15:0] rom_angle;
    logic signed [15:0] rom_val;
    logic signed [15:0] cos_reg;
    logic signed [24:0] ox_reg, oy_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic signed [23:0] wx, wy, rx, ry;

    logic signed [31:0] ma, mb;
    logic signed [63:0] mp;

    // line data (query line 1, edge line 2)
    logic signed [24:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [23:0] cx_reg, cy_reg, dx_reg, dy_reg;
    logic signed [51:0] c1_reg, c2_reg;
    logic signed [51:0] det_reg;
    logic signed [79:0] nx_reg, ny_reg;
    logic signed [63:0] acc_reg;
    logic signed [79:0] bnd_reg;
    logic ok_reg;

    tpi_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
        .clk(clk), .angle(rom_angle), .value(rom_val));
    tpi_vertex_ram #(.DEPTH(MAX_VERTICES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wx(wx), .wy(wy),
        .raddr(raddr), .rx(rx), .ry(ry));
    tpi_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);

    // scaled offset, rounded half away from zero
    function automatic logic signed [24:0] scale(input logic [15:0] hw,
                                                 input logic signed [15:0] t);
        logic [15:0] mt;
        logic [31:0] m;
        mt = t[15] ? 16'(-t) : 16'(t);
        m = (32'(hw) * 32'(mt) + 32'd8192) >> 14;
        return t[15] ? -$signed(25'(m)) : $signed(25'(m));
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607)
            return 24'sd8388607;
        if (v < -26'sd8388608)
            return -24'sd8388608;
        return 24'(v);
    endfunction

    function automatic logic signed [23:0] mn(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [23:0] mx(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [15:0] nrm;
    assign nrm = req_reg.heading + 16'd16384;
    assign rom_angle = (state_reg == S_AP_COS) ? nrm + 16'd16384 : nrm;

    logic full;
    assign full = (32'(count_reg) + 32'd2) > 32'(MAX_VERTICES);

    // memory port addresses, write enable and write data
    always_comb
    begin
        we = 1'b0;
        waddr = count_reg[AW-1:0];
        wx = sat24(26'(req_reg.start_x) + 26'(ox_reg));
        wy = sat24(26'(req_reg.start_y) + 26'(oy_reg));
        if (state_reg == S_AP_WR0)
            we = 1'b1;
        if (state_reg == S_AP_WR1)
        begin
            we = 1'b1;
            waddr = AW'(count_reg + 1'b1);
            wx = sat24(26'(req_reg.start_x) - 26'(ox_reg));
            wy = sat24(26'(req_reg.start_y) - 26'(oy_reg));
        end
        raddr = (state_reg == S_Q_RD0) ? AW'(idx_reg - 2'd2) : idx_reg[AW-1:0];
    end

    // overlap of the bounding boxes of both lines widened by 4 lsb, 26 bits signed
    logic signed [25:0] lox, hix, loy, hiy;
    always_comb
    begin
        lox = 26'(mx(mn(req_reg.start_x, req_reg.end_x), mn(cx_reg, dx_reg))) - 26'sd4;
        hix = 26'(mn(mx(req_reg.start_x, req_reg.end_x), mx(cx_reg, dx_reg))) + 26'sd4;
        loy = 26'(mx(mn(req_reg.start_y, req_reg.end_y), mn(cy_reg, dy_reg))) - 26'sd4;
        hiy = 26'(mn(mx(req_reg.start_y, req_reg.end_y), mx(cy_reg, dy_reg))) + 26'sd4;
    end

    // split of a signed 52-bit factor into low 26 (unsigned) and high (signed)
    logic signed [31:0] c1lo, c1hi, c2lo, c2hi;
    assign c1lo = 32'({1'b0, c1_reg[25:0]});
    assign c1hi = 32'($signed(c1_reg[51:26]));
    assign c2lo = 32'({1'b0, c2_reg[25:0]});
    assign c2hi = 32'($signed(c2_reg[51:26]));

    // det made positive, numerators follow its sign; det split like c1/c2
    logic signed [51:0] dabs;
    logic signed [79:0] nxs, nys;
    logic signed [31:0] dlo, dhi;
    always_comb
    begin
        dabs = det_reg[51] ? -det_reg : det_reg;
        nxs = det_reg[51] ? -nx_reg : nx_reg;
        nys = det_reg[51] ? -ny_reg : ny_reg;
        dlo = 32'({1'b0, dabs[25:0]});
        dhi = 32'($signed(dabs[51:26]));
    end

    // multiplier operand selection; the product comes back through the multiplier's product register
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_Q_LINE0: begin ma = 32'(a1_reg); mb = 32'(req_reg.start_x); end
            S_Q_LINE1: begin ma = 32'(b1_reg); mb = 32'(req_reg.start_y); end
            S_Q_E0:    begin ma = 32'(a2_reg); mb = 32'(cx_reg); end
            S_Q_E1:    begin ma = 32'(b2_reg); mb = 32'(cy_reg); end
            S_Q_E2:    begin ma = 32'(a1_reg); mb = 32'(b2_reg); end
            S_Q_E3:    begin ma = 32'(a2_reg); mb = 32'(b1_reg); end
            S_Q_E4:    begin ma = 32'(b2_reg); mb = c1lo; end
            S_Q_E5:    begin ma = 32'(b2_reg); mb = c1hi; end
            S_Q_E6:    begin ma = 32'(b1_reg); mb = c2lo; end
            S_Q_E7:    begin ma = 32'(b1_reg); mb = c2hi; end
            S_Q_E8:    begin ma = 32'(a1_reg); mb = c2lo; end
            S_Q_E9:    begin ma = 32'(a1_reg); mb = c2hi; end
            S_Q_E10:   begin ma = 32'(a2_reg); mb = c1lo; end
            S_Q_E11:   begin ma = 32'(a2_reg); mb = c1hi; end
            S_Q_B0:    begin ma = 32'(lox); mb = dlo; end
            S_Q_B1:    begin ma = 32'(lox); mb = dhi; end
            S_Q_B2:    begin ma = 32'(hix); mb = dlo; end
            S_Q_B3:    begin ma = 32'(hix); mb = dhi; end
            S_Q_B4:    begin ma = 32'(loy); mb = dlo; end
            S_Q_B5:    begin ma = 32'(loy); mb = dhi; end
            S_Q_B6:    begin ma = 32'(hiy); mb = dlo; end
            S_Q_B7:    begin ma = 32'(hiy); mb = dhi; end
            default:   begin ma = '0; mb = '0; end
        endcase
    end

    // final containment check: lo*det <= n <= hi*det, last bound finishes here
    logic in_box;
    assign in_box = ok_reg && (nys <= bnd_reg + (80'(mp) <<< 26));

    logic more_edges;
    assign more_edges = (32'(idx_reg) + 32'd1 < 32'(count_reg))
                        && (32'(idx_reg) < 32'(MAX_VERTICES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = (req.opcode == OP_QUERY) ? S_Q_LINE0 : S_AP_COS;
            S_AP_COS:  state_next = full ? S_DONE : S_AP_SIN;
            S_AP_SIN:  state_next = S_AP_OFS;
            S_AP_OFS:  state_next = S_AP_WR0;
            S_AP_WR0:  state_next = S_AP_WR1;
            S_AP_WR1:  state_next = S_DONE;
            S_Q_LINE0: state_next = S_Q_LINE1;
            S_Q_LINE1: state_next = S_Q_RD0;
            S_Q_RD0:   state_next = more_edges ? S_Q_RD1 : S_DONE;
            S_Q_RD1:   state_next = S_Q_RD2;
            S_Q_RD2:   state_next = S_Q_E0;
            S_Q_E0:    state_next = S_Q_E1;
            S_Q_E1:    state_next = S_Q_E2;
            S_Q_E2:    state_next = S_Q_E3;
            S_Q_E3:    state_next = S_Q_E4;
            S_Q_E4:    state_next = S_Q_E5;
            S_Q_E5:    state_next = S_Q_E6;
            S_Q_E6:    state_next = S_Q_E7;
            S_Q_E7:    state_next = S_Q_E8;
            S_Q_E8:    state_next = S_Q_E9;
            S_Q_E9:    state_next = S_Q_E10;
            S_Q_E10:   state_next = S_Q_E11;
            S_Q_E11:   state_next = S_Q_E12;
            S_Q_E12:   state_next = S_Q_B0;
            S_Q_B0:    state_next = S_Q_B1;
            S_Q_B1:    state_next = S_Q_B2;
            S_Q_B2:    state_next = S_Q_B3;
            S_Q_B3:    state_next = S_Q_B4;
            S_Q_B4:    state_next = S_Q_B5;
            S_Q_B5:    state_next = S_Q_B6;
            S_Q_B6:    state_next = S_Q_B7;
            S_Q_B7:    state_next = S_Q_CHK;
            S_Q_CHK:
                if (det_reg != 0 && in_box)
                    state_next = S_DONE;
                else
                    state_next = S_Q_RD0;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and the edge index
    always_comb
    begin
        done = (state_reg == S_DONE);
        res.hit = hit_reg;
        res.overflow = ovf_reg;
        if (state_reg == S_IDLE && start)
            idx_next = CW'(2);
        else if (state_reg == S_Q_CHK)
            idx_next = CW'(idx_reg + 1'b1);
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hw_reg <= HALF_WIDTH_RESET;
            count_reg <= '0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            if (cfg_valid && cfg_ready)
                hw_reg <= cfg_data;
            if (state_reg == S_IDLE && start)
            begin
                hit_reg <= 1'b0;
                ovf_reg <= 1'b0;
            end
            if (state_reg == S_AP_COS && full)
                ovf_reg <= 1'b1;
            if (state_reg == S_AP_WR1)
                count_reg <= CW'(count_reg + 2'd2);
            if (state_reg == S_Q_CHK && det_reg != 0 && in_box)
                hit_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req;
            a1_reg <= 25'(req.end_y) - 25'(req.start_y);
            b1_reg <= 25'(req.start_x) - 25'(req.end_x);
        end
        case (state_reg)
            S_AP_SIN: cos_reg <= rom_val;
            S_AP_OFS:
            begin
                ox_reg <= scale(hw_reg, cos_reg);
                oy_reg <= scale(hw_reg, rom_val);
            end
            S_Q_RD1:
            begin
                cx_reg <= rx;
                cy_reg <= ry;
            end
            S_Q_RD2:
            begin
                dx_reg <= rx;
                dy_reg <= ry;
                a2_reg <= 25'(ry) - 25'(cy_reg);
                b2_reg <= 25'(cx_reg) - 25'(rx);
            end
            S_Q_E1:   acc_reg <= mp;
            S_Q_E2:   c2_reg <= 52'(acc_reg + mp);
            S_Q_E3:   acc_reg <= mp;
            S_Q_E4:   det_reg <= 52'(acc_reg - mp);
            S_Q_E5:   nx_reg <= 80'(mp);
            S_Q_E6:   nx_reg <= nx_reg + (80'(mp) <<< 26);
            S_Q_E7:   nx_reg <= nx_reg - 80'(mp);
            S_Q_E8:   nx_reg <= nx_reg - (80'(mp) <<< 26);
            S_Q_E9:   ny_reg <= 80'(mp);
            S_Q_E10:  ny_reg <= ny_reg + (80'(mp) <<< 26);
            S_Q_E11:  ny_reg <= ny_reg - 80'(mp);
            S_Q_E12:  ny_reg <= ny_reg - (80'(mp) <<< 26);
            // each bound is low part plus high part shifted by 26
            S_Q_B1:   bnd_reg <= 80'(mp);
            S_Q_B2:   bnd_reg <= bnd_reg + (80'(mp) <<< 26);
            S_Q_B3:
            begin
                ok_reg <= (bnd_reg <= nxs);
                bnd_reg <= 80'(mp);
            end
            S_Q_B4:   bnd_reg <= bnd_reg + (80'(mp) <<< 26);
            S_Q_B5:
            begin
                ok_reg <= ok_reg && (nxs <= bnd_reg);
                bnd_reg <= 80'(mp);
            end
            S_Q_B6:   bnd_reg <= bnd_reg + (80'(mp) <<< 26);
            S_Q_B7:
            begin
                ok_reg <= ok_reg && (bnd_reg <= nys);
                bnd_reg <= 80'(mp);
            end
            default: ;
        endcase
        if (state_reg == S_Q_LINE1)
            acc_reg <= mp;
        if (state_reg == S_Q_RD0 && idx_reg == CW'(2))
            c1_reg <= 52'(acc_reg + mp);
    end

    // a result only follows a request
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a request");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(res.hit && res.overflow))
        else $error("hit and overflow together");
    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] == 1'b0)
        else $error("odd vertex count");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after done");
endmodule

/* tb/thick_polyline_intersection_checker.sv */
// result checker for thick_polyline_intersection: watches request, result and cfg
// channels, keeps its own vertex store and sine table; depends on tpi_pkg
`timescale 1ns / 1ps

module thick_polyline_intersection_checker
    import tpi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  req_t  req,
    input  logic  done,
    input  res_t  res,
    input  logic  cfg_valid,
    input  logic  cfg_ready,
    input  logic [15:0] cfg_data,
    output int    errors,
    output int    pending
);

    localparam int STORE_DEPTH = 1024;
    localparam int TABLE_DEPTH = 256;

    logic signed [15:0] sine_q14 [TABLE_DEPTH];
    logic signed [23:0] outline_x [STORE_DEPTH];
    logic signed [23:0] outline_y [STORE_DEPTH];
    int unsigned        outline_count;
    logic [15:0]        offset_width;
    res_t               expected_results [$];

    function automatic longint mul_q30(input longint a, input longint b);
        bit [63:0]  ma;
        bit [63:0]  mb;
        bit [127:0] p;
        longint     m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = ma * mb;
        m = longint'(p >> 30);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // odd polynomial on a quarter wave, folded by quadrant
    function automatic logic signed [15:0] sine_at_phase(input int unsigned phase);
        int unsigned quad;
        int unsigned r;
        longint      u;
        longint      u2;
        longint      s;
        longint      v;
        quad = (phase >> 14) & 3;
        r = phase & 16383;
        if (quad & 1)
            r = 16384 - r;
        u = longint'(r) << 16;
        u2 = mul_q30(u, u);
        s = 172272;
        s = -5026995 + mul_q30(s, u2);
        s = 85569306 + mul_q30(s, u2);
        s = -693598668 + mul_q30(s, u2);
        s = 1686629713 + mul_q30(s, u2);
        s = mul_q30(s, u);
        if (s < 0)
            s = 0;
        v = (s + 32768) >>> 16;
        if (v > 16384)
            v = 16384;
        return (quad >= 2) ? -16'(v) : 16'(v);
    endfunction

    function automatic longint offset_q8(input logic signed [15:0] t);
        longint m;
        longint mag;
        mag = (t < 0) ? -longint'(t) : longint'(t);
        m = (longint'(offset_width) * mag + 8192) >>> 14;
        return (t < 0) ? -m : m;
    endfunction

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > 8388607)
            return 24'sd8388607;
        if (v < -8388608)
            return -24'sd8388608;
        return 24'(v);
    endfunction

    function automatic logic signed [127:0] min128(input logic signed [127:0] a,
                                                   input logic signed [127:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [127:0] max128(input logic signed [127:0] a,
                                                   input logic signed [127:0] b);
        return (a > b) ? a : b;
    endfunction

    // exact crossing test, point compared as numerator against bound*det
    function automatic bit edge_crossed(input logic signed [127:0] ax, ay, bx, by,
                                        input logic signed [127:0] cx, cy, dx, dy);
        logic signed [127:0] a1, b1, c1, a2, b2, c2, det, nx, ny;
        logic signed [127:0] lox, hix, loy, hiy;
        a1 = by - ay;
        b1 = ax - bx;
        c1 = a1 * ax + b1 * ay;
        a2 = dy - cy;
        b2 = cx - dx;
        c2 = a2 * cx + b2 * cy;
        det = a1 * b2 - a2 * b1;
        if (det == 0)
            return 1'b0;
        nx = b2 * c1 - b1 * c2;
        ny = a1 * c2 - a2 * c1;
        if (det < 0)
        begin
            det = -det;
            nx = -nx;
            ny = -ny;
        end
        lox = max128(min128(ax, bx), min128(cx, dx)) - 4;
        hix = min128(max128(ax, bx), max128(cx, dx)) + 4;
        loy = max128(min128(ay, by), min128(cy, dy)) - 4;
        hiy = min128(max128(ay, by), max128(cy, dy)) + 4;
        return (lox * det <= nx) && (nx <= hix * det) &&
               (loy * det <= ny) && (ny <= hiy * det);
    endfunction

    function automatic res_t predict_result(input req_t r);
        res_t        e;
        int unsigned normal;
        longint      ox;
        longint      oy;
        e = '0;
        if (r.opcode == OP_APPEND)
        begin
            if (outline_count + 2 > STORE_DEPTH)
            begin
                e.overflow = 1'b1;
                return e;
            end
            normal = (int'(r.heading) + 16384) & 16'hFFFF;
            ox = offset_q8(sine_q14[((normal + 16384) & 16'hFFFF) >> 8]);
            oy = offset_q8(sine_q14[normal >> 8]);
            outline_x[outline_count]     = clamp24(longint'(r.start_x) + ox);
            outline_y[outline_count]     = clamp24(longint'(r.start_y) + oy);
            outline_x[outline_count + 1] = clamp24(longint'(r.start_x) - ox);
            outline_y[outline_count + 1] = clamp24(longint'(r.start_y) - oy);
            outline_count += 2;
        end
        else
        begin
            for (int unsigned i = 2; i + 1 < outline_count; i++)
            begin
                if (edge_crossed(r.start_x, r.start_y, r.end_x, r.end_y,
                                 outline_x[i - 2], outline_y[i - 2],
                                 outline_x[i], outline_y[i]))
                begin
                    e.hit = 1'b1;
                    break;
                end
            end
        end
        return e;
    endfunction

    initial
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
            sine_q14[k] = sine_at_phase(k * (65536 / TABLE_DEPTH));
    end

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            outline_count <= 0;
            offset_width <= HALF_WIDTH_RESET;
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            // result first; no new request is taken on the same edge, as busy is still high with done
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.hit !== want.hit)
                    begin
                        $error("hit: expected %0b, actual %0b", want.hit, res.hit);
                        errors = errors + 1;
                    end
                    if (res.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, res.overflow);
                        errors = errors + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                offset_width = cfg_data;
            if (start && !busy)
                expected_results = {expected_results, predict_result(req)};
        end
    end

endmodule

/* tb/thick_polyline_intersection_tb.sv */
// testbench top: clock, reset, request and cfg stimulus, verdict; depends on
// tpi_pkg, thick_polyline_intersection and thick_polyline_intersection_checker
`timescale 1ns / 1ps

module thick_polyline_intersection_tb;
    import tpi_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    res_t        res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          steady;
    logic signed [23:0] track_x [$];
    logic signed [23:0] track_y [$];

    thick_polyline_intersection u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    thick_polyline_intersection_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("thick_polyline_intersection_tb: errors");
            $finish;
        end
    end

    // busy only moves at the rising edge, so a low busy at the falling edge
    // means the request goes in at the next rising edge
    task automatic send(input req_t r);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic append(input int x, input int y, input int hd);
        req_t r;
        r = '0;
        r.opcode = OP_APPEND;
        r.start_x = 24'(x);
        r.start_y = 24'(y);
        r.end_x = 24'($urandom);
        r.end_y = 24'($urandom);
        r.heading = 16'(hd);
        send(r);
        track_x = {track_x, 24'(x)};
        track_y = {track_y, 24'(y)};
    endtask

    task automatic query(input int ax, input int ay, input int bx, input int by);
        req_t r;
        r.opcode = OP_QUERY;
        r.start_x = 24'(ax);
        r.start_y = 24'(ay);
        r.end_x = 24'(bx);
        r.end_y = 24'(by);
        r.heading = 16'($urandom);
        send(r);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_width(input logic [15:0] w);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= $urandom;
    endtask

    // mostly a connected walk with lines across it, plus full-range noise
    task automatic random_items(input int n);
        int cx;
        int cy;
        int k;
        for (int j = 0; j < n; j++)
        begin
            cx = track_x[$];
            cy = track_y[$];
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    append(cx + int'($urandom_range(0, 4096)) - 2048,
                           cy + int'($urandom_range(0, 4096)) - 2048,
                           $urandom);
                5:
                    append(int'($urandom), int'($urandom), $urandom);
                6:
                    query(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
                default:
                begin
                    k = $urandom_range(0, track_x.size() - 1);
                    cx = track_x[k];
                    cy = track_y[k];
                    query(cx + int'($urandom_range(0, 8192)) - 4096,
                          cy + int'($urandom_range(0, 8192)) - 4096,
                          cx + int'($urandom_range(0, 8192)) - 4096,
                          cy + int'($urandom_range(0, 8192)) - 4096);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        steady = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // too few vertices for any edge
        query(-1000, -1000, 1000, 1000);
        append(0, 0, 0);
        query(-1000, -1000, 1000, 1000);
        // straight track along x, outline at y = +-1.0
        append(512, 0, 0);
        append(1024, 0, 0);
        append(1536, 0, 0);
        query(256, -1000, 256, 1000);
        query(-2000, 256, 4000, 256);
        query(100000, 100000, 100100, 90000);
        query(1, 250, 1, 1000);
        // headings at the quarter points and extremes, saturating vertices
        append(8388607, 8388607, 16384);
        append(-8388608, -8388608, 32768);
        append(8388607, -8388608, 49152);
        append(-8388608, 8388607, 65535);
        query(8388607, 8388607, -8388608, -8388608);
        query(-8388608, 8388607, 8388607, -8388608);
        append(2048, 0, 0);
        append(2560, 0, 0);
        query(2300, -8388608, 2300, 8388607);
        query(0, 0, 0, 0);

        set_width(16'd0);
        random_items(25);
        set_width(16'hFFFF);
        random_items(25);
        set_width(16'($urandom));
        random_items(25);
        set_width(16'd640);
        random_items(25);

        // no idling from here
        steady = 1'b1;
        set_width(16'd256);
        random_items(20);
        query(-8388608, -8388608, 8388607, 8388607);

        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("thick_polyline_intersection_tb: clean");
        else
            $display("thick_polyline_intersection_tb: errors");
        $finish;
    end

endmodule
